/* sv/assert_macros.svh */
// assertion macros shared by the sketch rtl
// no dependencies; expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on clk, off during reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

/* sv/hll_pkg.sv */
// types, codes and helper functions for the hyperloglog sketch store
// no dependencies
package hll_pkg;

	localparam int HASH_W    = 64;
	localparam int VAL_W     = 6;
	localparam int MIDX_W    = 14;
	localparam int ZOUT_W    = 15;
	localparam int SUM_W     = 64;
	localparam int FRAC_BITS = 49;
	localparam int PREC_W    = 4;
	localparam int PREC_MIN  = 4;

	localparam logic [PREC_W-1:0] PREC_RESET = 4'd14;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_MERGE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [HASH_W-1:0] hash_value;
		logic [MIDX_W-1:0] merge_index;
		logic [VAL_W-1:0]  merge_value;
	} hll_in_t;

	typedef struct packed {
		logic [VAL_W-1:0]  bucket_value;
		logic [ZOUT_W-1:0] zero_count;
		logic [SUM_W-1:0]  harmonic_sum;
	} hll_out_t;

	// position of the highest set bit, zero for a zero word
	function automatic logic [5:0] floor_log2_64(input logic [HASH_W-1:0] w);
		logic [5:0] n;
		n = '0;
		for (int i = 1; i < HASH_W; i++) begin
			if (w[i]) n = 6'(i);
		end
		return n;
	endfunction

	// 2^-v with FRAC_BITS fraction bits, truncated to zero below the lsb
	function automatic logic [SUM_W-1:0] term_of(input logic [VAL_W-1:0] v);
		logic [SUM_W-1:0] t;
		if (v > VAL_W'(FRAC_BITS)) t = '0;
		else t = SUM_W'(1) << (VAL_W'(FRAC_BITS) - v);
		return t;
	endfunction

endpackage

/* sv/hll_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module hll_ram #(
	parameter int DATA_W = 6,
	parameter int DEPTH  = 16384
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [DATA_W-1:0]          wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [DATA_W-1:0]          rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

/* sv/hyperloglog_sketch_update.sv */
// hyperloglog sketch store: bucket memory, zero count and harmonic sum
// depends on hll_pkg, hll_ram and assert_macros.svh
//
// usage
//   input channel in_valid/in_stall/in_item: one request per item (add hash,
//   merge a bucket value, or read statistics). output channel out_valid/
//   out_stall/out_item: exactly one result item per request, in order.
//   precision is written through cfg_wr_en/cfg_wr_data while the block is idle.
// pipeline and rate
//   an accepted item passes the first stage (ram read) and then the output register.
//   one item per cycle while the output drains; the bucket ram read in the
//   first stage and the read-modify-write of the second stage set this.
//   back-to-back hits on the same bucket are covered by a forwarding register.
// reset and precision writes
//   reset and every precision write start a clearing pass that writes zero
//   to all 2^MAX_PRECISION buckets, one per cycle; in_stall stays high for
//   those cycles. zero count and sum restart at 2^p and 2^p scaled.
// stalls
//   a stalled result stays in the output register; one more item can be
//   accepted and waits in the first stage with its ram read held.
`include "assert_macros.svh"

module hyperloglog_sketch_update
	import hll_pkg::*;
#(
	parameter int MAX_PRECISION = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [PREC_W-1:0]   cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  hll_in_t             in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output hll_out_t            out_item
);

	localparam int IDX_W = MAX_PRECISION;
	localparam int DEPTH = 1 << MAX_PRECISION;
	localparam int PW    = $clog2(MAX_PRECISION + 1);
	localparam int ZC_W  = MAX_PRECISION + 1;

	// precision saturated into the supported range
	function automatic logic [PW-1:0] sat_prec(input logic [PREC_W-1:0] p);
		logic [PW-1:0] r;
		if (32'(p) < PREC_MIN) r = PW'(PREC_MIN);
		else if (32'(p) > MAX_PRECISION) r = PW'(MAX_PRECISION);
		else r = PW'(p);
		return r;
	endfunction

	// configuration and running statistics
	logic [PREC_W-1:0] prec_q;
	logic [PW-1:0]     p_eff;
	logic [ZC_W-1:0]   zc_q;
	logic [SUM_W-1:0]  sum_q;

	// clearing pass
	logic              clr_busy_q;
	logic [IDX_W-1:0]  clr_cnt_q;

	// input decode
	logic              accept;
	logic              upd_in;
	logic [IDX_W-1:0]  idx_mask;
	logic [IDX_W-1:0]  idx_in;
	logic [31:0]       merge_ext;
	logic [HASH_W-1:0] hash_hi;
	logic [VAL_W-1:0]  rho;
	logic [VAL_W-1:0]  v_in;

	// stage 1: ram read in flight
	logic              valid_s1;
	logic              upd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [VAL_W-1:0]  v_s1;
	logic [SUM_W-1:0]  term_v_s1;
	logic              fwd_hit_s1;
	logic [VAL_W-1:0]  fwd_val_s1;

	// stage 2: modify and write back
	logic              adv;
	logic [VAL_W-1:0]  ram_rdata;
	logic [VAL_W-1:0]  old_val;
	logic              raise;
	logic [VAL_W-1:0]  new_bucket;
	logic [ZC_W-1:0]   zc_next;
	logic [SUM_W-1:0]  sum_next;
	logic [31:0]       zc_ext;
	logic              hit_in;

	// ram ports
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;

	// output register
	logic              out_valid_q;
	hll_out_t          out_item_q;

	assign p_eff = sat_prec(prec_q);

	// handshake
	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = clr_busy_q | (valid_s1 & ~adv);
	assign accept   = in_valid & ~in_stall;

	// bucket index and candidate value of the incoming item
	always_comb begin
		for (int i = 0; i < IDX_W; i++) begin
			idx_mask[i] = (32'(p_eff) > i);
		end
		// hash bits above the index field; rho counts from the top of the word
		for (int i = 0; i < HASH_W; i++) begin
			hash_hi[i] = in_item.hash_value[i] & (32'(p_eff) <= i);
		end
		if (hash_hi == '0) rho = VAL_W'(7'(HASH_W + 1) - 7'(p_eff));
		else rho = VAL_W'(7'(HASH_W) - {1'b0, floor_log2_64(hash_hi)});
		merge_ext = 32'(in_item.merge_index);
		unique case (in_item.req_type)
			REQ_ADD: begin
				upd_in = 1'b1;
				idx_in = in_item.hash_value[IDX_W-1:0] & idx_mask;
				v_in   = rho;
			end
			REQ_MERGE: begin
				upd_in = 1'b1;
				idx_in = merge_ext[IDX_W-1:0] & idx_mask;
				v_in   = in_item.merge_value;
			end
			REQ_READ: begin
				upd_in = 1'b0;
				idx_in = '0;
				v_in   = '0;
			end
			default: begin
				// unused code reads statistics only
				upd_in = 1'b0;
				idx_in = '0;
				v_in   = '0;
			end
		endcase
	end

	// same bucket as the item writing back this cycle: its ram read is stale
	assign hit_in = adv & upd_s1 & upd_in & (idx_in == idx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// forward flag lives only as long as its item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			fwd_hit_s1 <= hit_in;
		end else if (adv) begin
			fwd_hit_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upd_s1     <= upd_in;
			idx_s1     <= idx_in;
			v_s1       <= v_in;
			term_v_s1  <= term_of(v_in);
			fwd_val_s1 <= new_bucket;
		end
	end

	// read-modify-write of the addressed bucket
	always_comb begin
		old_val    = fwd_hit_s1 ? fwd_val_s1 : ram_rdata;
		raise      = upd_s1 & (v_s1 > old_val);
		new_bucket = raise ? v_s1 : old_val;
		zc_next    = (raise && old_val == '0) ? zc_q - ZC_W'(1) : zc_q;
		sum_next   = raise ? sum_q - term_of(old_val) + term_v_s1 : sum_q;
		zc_ext     = 32'(zc_next);
	end

	// statistics and precision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= PREC_RESET;
			zc_q   <= ZC_W'(1) << sat_prec(PREC_RESET);
			sum_q  <= SUM_W'(1) << (7'(sat_prec(PREC_RESET)) + 7'(FRAC_BITS));
		end else if (cfg_wr_en) begin
			prec_q <= cfg_wr_data;
			zc_q   <= ZC_W'(1) << sat_prec(cfg_wr_data);
			sum_q  <= SUM_W'(1) << (7'(sat_prec(cfg_wr_data)) + 7'(FRAC_BITS));
		end else if (adv) begin
			zc_q   <= zc_next;
			sum_q  <= sum_next;
		end
	end

	// clearing pass over the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (cfg_wr_en) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (clr_cnt_q == IDX_W'(DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	assign ram_we    = clr_busy_q | (adv & raise);
	assign ram_waddr = clr_busy_q ? clr_cnt_q : idx_s1;
	assign ram_wdata = clr_busy_q ? '0 : v_s1;

	hll_ram #(
		.DATA_W (VAL_W),
		.DEPTH  (DEPTH)
	) u_bucket_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q.bucket_value <= upd_s1 ? new_bucket : '0;
			out_item_q.zero_count   <= zc_ext[ZOUT_W-1:0];
			out_item_q.harmonic_sum <= sum_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`ASSERT_IMPL(a_clear_no_items, clr_busy_q, !valid_s1, "item in flight during clearing")
	`ASSERT_CLK(a_adv_loads_out, adv |=> out_valid_q, "result lost after write back")
	`ASSERT_IMPL(a_fwd_needs_upd, fwd_hit_s1, valid_s1 && upd_s1, "forward without update")
	`ASSERT_CLK(a_zero_bound, zc_q <= (ZC_W'(1) << p_eff), "zero count above bucket count")

endmodule
